### rtl/spi_master_fifo_exchange_unit_macros.svh
// assertion macros shared by the spi master fifo exchange unit
`ifndef SPI_MASTER_FIFO_EXCHANGE_UNIT_MACROS_SVH
`define SPI_MASTER_FIFO_EXCHANGE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMFX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smfx assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SMFX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smfx assertion failed");

`endif

### rtl/smfx_pkg.sv
// types and constants of the spi master fifo exchange unit
`timescale 1ns / 1ps

package smfx_pkg;

    typedef logic [15:0] word_t;
    typedef logic [4:0]  bit_count_t;
    typedef logic [3:0]  nibble_t;

    typedef enum logic [1:0] {
        OP_TX_WRITE = 2'd0,
        OP_RX_READ  = 2'd1,
        OP_CONTROL  = 2'd2,
        OP_RESPONSE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_DRAIN_RD,
        ST_DRAIN_WR
    } state_t;

    localparam int CTRL_ENABLE_BIT   = 9;
    localparam int CTRL_EXCHANGE_BIT = 8;

    localparam word_t IDLE_FILL = 16'h00ff;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_SHIFT = 1'b1;

    // register index of the card select bit (paddr bit 2)
    localparam logic REG_CARD_SELECT = 1'b0;

endpackage

### rtl/smfx_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module smfx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/spi_master_fifo_exchange_unit.sv
// top level of the spi master fifo exchange unit
`timescale 1ns / 1ps
// Register block of an spi master with a transmit fifo and a receive fifo.
// Input channel (in_valid/in_ready, opcode, data) carries one bus access:
// transmit write, receive read, control write or card response push.
// Output channel (out_valid/out_ready, kind, word, bit_count, last) carries
// receive read data and words shifted out to the card.
// Transmit writes and response pushes give no result.
// A receive read gives its result through the receive ram read register and
// the output register: the ram is read when the read is accepted, and the
// output register loads once it is free.
// A control write with enable and exchange set drains the transmit fifo one
// entry at a time in two steps (ram read, then output load or receive push);
// the output load waits while the output register is full.
// in_ready is high only while no access is in progress; a finished result
// may still sit in the output register while the next access is accepted.
// If the receiver stalls, the block waits for the output register to empty
// before placing the next result; no result is lost.
// Reset clears pointers, empty flags, control and card select; fifo ram
// contents are undefined until written and need no clearing pass.
// The apb port holds the card select bit wherever paddr bit 2 is clear; pready is tied high.

`include "spi_master_fifo_exchange_unit_macros.svh"

module spi_master_fifo_exchange_unit #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] data,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] word,
    output logic [4:0]  bit_count,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    smfx_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] tx_head_reg, tx_head_next;
    logic [PTR_W-1:0] tx_tail_reg, tx_tail_next;
    logic [PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [PTR_W-1:0] rx_tail_reg, rx_tail_next;
    logic             tx_empty_reg, tx_empty_next;
    logic             rx_empty_reg, rx_empty_next;
    smfx_pkg::nibble_t count_reg, count_next;
    logic             card_sel_reg;
    logic             rd_hit_reg, rd_hit_next;
    logic             drain_last_reg, drain_last_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   kind_reg, kind_next;
    smfx_pkg::word_t        word_reg, word_next;
    smfx_pkg::bit_count_t   bit_count_reg, bit_count_next;
    logic                   last_reg, last_next;

    // ram ports
    logic             tx_we, tx_re, rx_we, rx_re;
    smfx_pkg::word_t  tx_rdata, rx_rdata, rx_wdata;

    logic in_fire, out_free, load_out, tx_full, rx_avail, cfg_write;
    logic exchange_req;

    assign in_ready  = (state_reg == smfx_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign tx_full   = !tx_empty_reg && (tx_head_reg == tx_tail_reg);
    assign rx_avail  = !(rx_empty_reg && (rx_head_reg == rx_tail_reg));
    assign exchange_req = data[smfx_pkg::CTRL_ENABLE_BIT] &&
                          data[smfx_pkg::CTRL_EXCHANGE_BIT];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == smfx_pkg::REG_CARD_SELECT) ?
                       {31'd0, card_sel_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_sel_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == smfx_pkg::REG_CARD_SELECT))
        begin
            card_sel_reg <= pwdata[0];
        end
    end

    smfx_ram #(
        .WIDTH (16),
        .DEPTH (FIFO_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (data),
        .re    (tx_re),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    smfx_ram #(
        .WIDTH (16),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smfx_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (smfx_pkg::opcode_t'(opcode))
                        smfx_pkg::OP_RX_READ:
                        begin
                            state_next = smfx_pkg::ST_RD_WAIT;
                        end
                        smfx_pkg::OP_CONTROL:
                        begin
                            if (exchange_req && !tx_empty_reg)
                            begin
                                state_next = smfx_pkg::ST_DRAIN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = smfx_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            smfx_pkg::ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    state_next = smfx_pkg::ST_IDLE;
                end
            end
            smfx_pkg::ST_DRAIN_RD:
            begin
                state_next = smfx_pkg::ST_DRAIN_WR;
            end
            smfx_pkg::ST_DRAIN_WR:
            begin
                if (!card_sel_reg || out_free)
                begin
                    state_next = drain_last_reg ? smfx_pkg::ST_IDLE
                                                : smfx_pkg::ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = smfx_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_empty_next   = tx_empty_reg;
        rx_empty_next   = rx_empty_reg;
        count_next      = count_reg;
        rd_hit_next     = rd_hit_reg;
        drain_last_next = drain_last_reg;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        rx_wdata        = data;
        load_out        = 1'b0;
        kind_next       = kind_reg;
        word_next       = word_reg;
        bit_count_next  = bit_count_reg;
        last_next       = last_reg;

        case (state_reg)
            smfx_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (smfx_pkg::opcode_t'(opcode))
                        smfx_pkg::OP_TX_WRITE:
                        begin
                            // dropped when full
                            if (!tx_full)
                            begin
                                tx_we         = 1'b1;
                                tx_head_next  = next_ptr(tx_head_reg);
                                tx_empty_next = 1'b0;
                            end
                        end
                        smfx_pkg::OP_RX_READ:
                        begin
                            rd_hit_next = rx_avail;
                            if (rx_avail)
                            begin
                                rx_re        = 1'b1;
                                rx_tail_next = next_ptr(rx_tail_reg);
                                if (next_ptr(rx_tail_reg) == rx_head_reg)
                                begin
                                    rx_empty_next = 1'b1;
                                end
                            end
                        end
                        smfx_pkg::OP_CONTROL:
                        begin
                            count_next = data[3:0];
                            // enable clear flushes both fifos
                            if (!data[smfx_pkg::CTRL_ENABLE_BIT])
                            begin
                                tx_tail_next  = tx_head_reg;
                                rx_tail_next  = rx_head_reg;
                                tx_empty_next = 1'b1;
                                rx_empty_next = 1'b1;
                            end
                        end
                        smfx_pkg::OP_RESPONSE:
                        begin
                            // no full check, wraps over the oldest entry
                            rx_we         = 1'b1;
                            rx_wdata      = data;
                            rx_head_next  = next_ptr(rx_head_reg);
                            rx_empty_next = 1'b0;
                        end
                        default:
                        begin
                            rx_we = 1'b0;
                        end
                    endcase
                end
            end
            smfx_pkg::ST_RD_WAIT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    kind_next      = smfx_pkg::KIND_READ;
                    word_next      = rd_hit_reg ? rx_rdata : '0;
                    bit_count_next = '0;
                    last_next      = 1'b1;
                end
            end
            smfx_pkg::ST_DRAIN_RD:
            begin
                tx_re           = 1'b1;
                tx_tail_next    = next_ptr(tx_tail_reg);
                drain_last_next = (next_ptr(tx_tail_reg) == tx_head_reg);
            end
            smfx_pkg::ST_DRAIN_WR:
            begin
                if (card_sel_reg)
                begin
                    if (out_free)
                    begin
                        load_out       = 1'b1;
                        kind_next      = smfx_pkg::KIND_SHIFT;
                        word_next      = tx_rdata;
                        bit_count_next = smfx_pkg::bit_count_t'(count_reg) +
                                         smfx_pkg::bit_count_t'(1);
                        last_next      = drain_last_reg;
                        if (drain_last_reg)
                        begin
                            tx_empty_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // card idle: each drained word returns IDLE_FILL, 0x00ff
                    rx_we         = 1'b1;
                    rx_wdata      = smfx_pkg::IDLE_FILL;
                    rx_head_next  = next_ptr(rx_head_reg);
                    rx_empty_next = 1'b0;
                    if (drain_last_reg)
                    begin
                        tx_empty_next = 1'b1;
                    end
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smfx_pkg::ST_IDLE;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_empty_reg   <= 1'b1;
            rx_empty_reg   <= 1'b1;
            count_reg      <= '0;
            rd_hit_reg     <= 1'b0;
            drain_last_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_empty_reg   <= tx_empty_next;
            rx_empty_reg   <= rx_empty_next;
            count_reg      <= count_next;
            rd_hit_reg     <= rd_hit_next;
            drain_last_reg <= drain_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        word_reg      <= word_next;
        bit_count_reg <= bit_count_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign word      = word_reg;
    assign bit_count = bit_count_reg;
    assign last      = last_reg;

    // an empty fifo has its pointers together
    `SMFX_ASSERT_NOW(a_tx_empty_ptrs, tx_empty_reg, tx_head_reg == tx_tail_reg)
    `SMFX_ASSERT_NOW(a_rx_empty_ptrs, rx_empty_reg, rx_head_reg == rx_tail_reg)
    // a drain step only starts on a non-empty transmit fifo
    `SMFX_ASSERT_NOW(a_drain_nonempty, state_reg == smfx_pkg::ST_DRAIN_RD, !tx_empty_reg)
    // a receive read transaction always goes to the read wait state
    `SMFX_ASSERT_NEXT(a_read_wait,
        in_fire && (opcode == smfx_pkg::OP_RX_READ),
        state_reg == smfx_pkg::ST_RD_WAIT)

endmodule
